### sv/bfir_pkg.sv
// Shared types and constants for the box filter image rescaler.
// No dependencies.
package bfir_pkg;
   localparam int SizeWidth = 9;
   localparam int PixWidth = 24;
   localparam logic COMMAND_LOAD = 1'b0;
   localparam logic COMMAND_COMPUTE = 1'b1;
   localparam logic [1:0] CSR_SOURCE_WIDTH = 2'd0;
   localparam logic [1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TARGET_WIDTH = 2'd2;
   localparam logic [1:0] CSR_TARGET_HEIGHT = 2'd3;
   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // write store
      logic start;       // latch destination, begin box bounds division
      logic bound_step;  // one restoring divider step on all four bounds
      logic bound_fix;   // widen and clip boxes
      logic walk_first;  // set cursors to box origin, clear sums
      logic walk_read;   // issue store read, advance cursor
      logic walk_acc;    // accumulate read data
      logic avg_start;   // begin channel division
      logic avg_step;    // one channel divider step
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic box_empty;
      logic walk_last;
   } stat_type;
endpackage

### sv/bfir_if.sv
// Handshake channel interfaces for the rescaler.
// No dependencies.
interface bfir_req_if;
   logic valid;
   logic ready;
   logic command;
   logic [15:0] pixel_index;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic [7:0] dest_x;
   logic [7:0] dest_y;
   modport source (output valid, command, pixel_index, red_in, green_in, blue_in,
                   dest_x, dest_y, input ready);
   modport sink (input valid, command, pixel_index, red_in, green_in, blue_in,
                 dest_x, dest_y, output ready);
endinterface

interface bfir_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;
   modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
   modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

interface bfir_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [8:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### sv/box_filter_image_rescale.sv
// Top level of the area-average image rescaler: channels, size registers,
// controller and datapath. Depends on bfir_pkg, bfir_if, bfir_ctrl, bfir_datapath.
//
//   channel  dir  payload
//   req      in   command, pixel_index, red/green/blue_in, dest_x, dest_y
//   rsp      out  red/green/blue/alpha_out
//   csr      in   index (2 bits), data (9 bits)
//
// A compute runs the box bounds (four 18-step restoring dividers, one per
// bound), reads the store once per box pixel, then runs the restoring mean
// divider, then the handoff. The frame store has no clearing pass; an unwritten
// entry reads undefined. Reset is synchronous; a stalled response holds the
// block in its done state.
module box_filter_image_rescale #(
   parameter int MAX_SOURCE_WIDTH = 256,
   parameter int MAX_SOURCE_HEIGHT = 256
) (
   input logic clock,
   input logic reset,
   bfir_req_if.sink req,
   bfir_rsp_if.source rsp,
   bfir_csr_if.sink csr
);
   localparam int SumBits = 8 + $clog2(MAX_SOURCE_WIDTH + 1) + $clog2(MAX_SOURCE_HEIGHT + 1);

   logic [8:0] source_width_ff, source_height_ff, target_width_ff, target_height_ff;
   bfir_pkg::cmd_type cmd;
   bfir_pkg::stat_type stat;
   bfir_pkg::rgb_type pixel_in, mean;
   logic csr_ready;

   assign csr.ready = csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff <= 9'd1;
         source_height_ff <= 9'd1;
         target_width_ff <= 9'd1;
         target_height_ff <= 9'd1;
      end else if (csr.valid && csr_ready) begin
         case (csr.index)
            bfir_pkg::CSR_SOURCE_WIDTH: source_width_ff <= csr.data;
            bfir_pkg::CSR_SOURCE_HEIGHT: source_height_ff <= csr.data;
            bfir_pkg::CSR_TARGET_WIDTH: target_width_ff <= csr.data;
            bfir_pkg::CSR_TARGET_HEIGHT: target_height_ff <= csr.data;
            default: ;
         endcase
      end
   end

   assign pixel_in.red = req.red_in;
   assign pixel_in.green = req.green_in;
   assign pixel_in.blue = req.blue_in;

   bfir_ctrl #(.SUM_BITS(SumBits)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_command(req.command), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .csr_ready(csr_ready),
      .stat(stat), .cmd(cmd)
   );

   bfir_datapath #(
      .MAX_SOURCE_WIDTH(MAX_SOURCE_WIDTH), .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT)
   ) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .pixel_index(req.pixel_index), .pixel_in(pixel_in),
      .dest_x(req.dest_x), .dest_y(req.dest_y),
      .source_width(source_width_ff), .source_height(source_height_ff),
      .target_width(target_width_ff), .target_height(target_height_ff),
      .mean_out(mean)
   );

   assign rsp.red_out = mean.red;
   assign rsp.green_out = mean.green;
   assign rsp.blue_out = mean.blue;
   assign rsp.alpha_out = bfir_pkg::ALPHA_OPAQUE;
endmodule

### sv/bfir_datapath.sv
// Datapath: source store, box bound dividers, box walk sums and mean dividers.
// Depends on bfir_pkg.
module bfir_datapath #(
   parameter int MAX_SOURCE_WIDTH = 256,
   parameter int MAX_SOURCE_HEIGHT = 256
) (
   input  logic clock,
   input  logic reset,
   input  bfir_pkg::cmd_type cmd,
   output bfir_pkg::stat_type stat,
   input  logic [15:0] pixel_index,
   input  bfir_pkg::rgb_type pixel_in,
   input  logic [7:0] dest_x,
   input  logic [7:0] dest_y,
   input  logic [8:0] source_width,
   input  logic [8:0] source_height,
   input  logic [8:0] target_width,
   input  logic [8:0] target_height,
   output bfir_pkg::rgb_type mean_out
);
   localparam int Depth = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int XW = $clog2(MAX_SOURCE_WIDTH + 1);
   localparam int YW = $clog2(MAX_SOURCE_HEIGHT + 1);
   localparam int SW = (XW > YW) ? XW : YW;     // clamped source size width
   localparam int NW = 18;                      // numerator width: 9 + 9 bits
   localparam int CntW = XW + YW;               // pixel count width
   localparam int SumW = 8 + CntW;

   bfir_pkg::rgb_type store [Depth];
   bfir_pkg::rgb_type rd_ff;

   logic [AddrW-1:0] st_addr;
   logic [AddrW-1:0] rd_addr;
   logic [31:0] idx_wide;

   // clamped sizes
   logic [SW-1:0] sw_c, sh_c;
   logic [8:0] tw_c, th_c;

   // bound dividers: quotients and remainders for x0, x1, y0, y1
   logic [NW-1:0] num_ff [4];
   logic [NW-1:0] num_in [4];
   logic [9:0] rem_ff [4];
   logic [9:0] rem_in [4];
   logic [NW-1:0] quo_ff [4];
   logic [NW-1:0] quo_in [4];

   logic [SW-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic [SW-1:0] x0_in, x1_in, y0_in, y1_in;
   logic [SW-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic [SW-1:0] sw_r_ff;
   logic [AddrW+SW:0] row_ff, row_in;
   logic [SumW-1:0] sum_ff [3];
   logic [SumW-1:0] sum_in [3];
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [SumW+8-1:0] arem_ff [3];
   logic [SumW+8-1:0] arem_in [3];
   logic [SumW-1:0] anum_ff [3];
   logic [SumW-1:0] anum_in [3];
   logic [7:0] aq_ff [3];
   logic [7:0] aq_in [3];

   function automatic logic [SW-1:0] clamp_src(logic [8:0] v, int unsigned lim);
      logic [SW-1:0] r;
      if (v == 9'd0) r = SW'(1);
      else if (32'(v) > lim) r = SW'(lim);
      else r = SW'(v);
      return r;
   endfunction

   always_comb begin
      sw_c = clamp_src(source_width, MAX_SOURCE_WIDTH);
      sh_c = clamp_src(source_height, MAX_SOURCE_HEIGHT);
      tw_c = (target_width == 9'd0) ? 9'd1 : target_width;
      th_c = (target_height == 9'd0) ? 9'd1 : target_height;
   end

   assign st_addr = pixel_index[AddrW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load && (32'(pixel_index) < Depth)) begin
         store[st_addr] <= pixel_in;
      end
   end

   // bounds: one restoring step per cycle, 18 steps
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         logic [10:0] trial;
         logic [8:0] d;
         d = (k < 2) ? tw_c : th_c;
         trial = {rem_ff[k], num_ff[k][NW-1]} - {2'b0, d};
         num_in[k] = num_ff[k];
         rem_in[k] = rem_ff[k];
         quo_in[k] = quo_ff[k];
         if (cmd.start) begin
            rem_in[k] = '0;
            quo_in[k] = '0;
         end else if (cmd.bound_step) begin
            num_in[k] = {num_ff[k][NW-2:0], 1'b0};
            if (!trial[10]) begin
               rem_in[k] = trial[9:0];
               quo_in[k] = {quo_ff[k][NW-2:0], 1'b1};
            end else begin
               rem_in[k] = {rem_ff[k][8:0], num_ff[k][NW-1]};
               quo_in[k] = {quo_ff[k][NW-2:0], 1'b0};
            end
         end
      end
      if (cmd.start) begin
         num_in[0] = NW'(dest_x) * NW'(sw_c);
         num_in[1] = NW'({1'b0, dest_x} + 9'd1) * NW'(sw_c);
         num_in[2] = NW'(dest_y) * NW'(sh_c);
         num_in[3] = NW'({1'b0, dest_y} + 9'd1) * NW'(sh_c);
      end
   end

   // widen then clip; lower bound may be clipped to the edge (empty box)
   function automatic logic [SW-1:0] box_hi(logic [NW-1:0] a, logic [NW-1:0] b,
                                            logic [SW-1:0] s);
      logic [NW-1:0] h;
      h = (b <= a) ? a + NW'(1) : b;
      if (h > NW'(s)) h = NW'(s);
      return h[SW-1:0];
   endfunction

   function automatic logic [SW-1:0] box_lo(logic [NW-1:0] a, logic [SW-1:0] s);
      return (a > NW'(s)) ? s : a[SW-1:0];
   endfunction

   always_comb begin
      x0_in = x0_ff; x1_in = x1_ff; y0_in = y0_ff; y1_in = y1_ff;
      if (cmd.bound_fix) begin
         x0_in = box_lo(quo_ff[0], sw_c);
         x1_in = box_hi(quo_ff[0], quo_ff[1], sw_c);
         y0_in = box_lo(quo_ff[2], sh_c);
         y1_in = box_hi(quo_ff[2], quo_ff[3], sh_c);
      end
   end

   assign stat.box_empty = (x0_ff >= x1_ff) || (y0_ff >= y1_ff);
   assign stat.walk_last = (cx_ff + SW'(1) == x1_ff) && (cy_ff + SW'(1) == y1_ff);

   // walk the box one pixel per cycle; row base accumulates by source width
   always_comb begin
      cx_in = cx_ff; cy_in = cy_ff; row_in = row_ff;
      idx_wide = 32'(row_ff) + 32'(cx_ff);
      rd_addr = idx_wide[AddrW-1:0];
      if (cmd.walk_first) begin
         cx_in = x0_ff;
         cy_in = y0_ff;
         row_in = (AddrW+SW+1)'(y0_ff) * (AddrW+SW+1)'(sw_c);
      end else if (cmd.walk_read) begin
         if (cx_ff + SW'(1) == x1_ff) begin
            cx_in = x0_ff;
            cy_in = cy_ff + SW'(1);
            row_in = row_ff + (AddrW+SW+1)'(sw_r_ff);
         end else begin
            cx_in = cx_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_read) rd_ff <= store[rd_addr];
   end

   always_comb begin
      for (int c = 0; c < 3; c++) sum_in[c] = sum_ff[c];
      cnt_in = cnt_ff;
      if (cmd.walk_first) begin
         for (int c = 0; c < 3; c++) sum_in[c] = '0;
         cnt_in = '0;
      end else if (cmd.walk_acc) begin
         sum_in[0] = sum_ff[0] + SumW'(rd_ff.red);
         sum_in[1] = sum_ff[1] + SumW'(rd_ff.green);
         sum_in[2] = sum_ff[2] + SumW'(rd_ff.blue);
         cnt_in = cnt_ff + CntW'(1);
      end
   end

   // channel means: one restoring step per cycle over SumW bits
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [SumW+8:0] t;
         t = {1'b0, arem_ff[c][SumW+6:0], anum_ff[c][SumW-1]} - (SumW+9)'(cnt_ff);
         anum_in[c] = anum_ff[c];
         arem_in[c] = arem_ff[c];
         aq_in[c] = aq_ff[c];
         if (cmd.avg_start) begin
            anum_in[c] = sum_ff[c];
            arem_in[c] = '0;
            aq_in[c] = '0;
         end else if (cmd.avg_step) begin
            anum_in[c] = {anum_ff[c][SumW-2:0], 1'b0};
            if (!t[SumW+8]) begin
               arem_in[c] = t[SumW+7:0];
               aq_in[c] = {aq_ff[c][6:0], 1'b1};
            end else begin
               arem_in[c] = {arem_ff[c][SumW+6:0], anum_ff[c][SumW-1]};
               aq_in[c] = {aq_ff[c][6:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         num_ff[k] <= num_in[k];
         rem_ff[k] <= rem_in[k];
         quo_ff[k] <= quo_in[k];
      end
      x0_ff <= x0_in; x1_ff <= x1_in; y0_ff <= y0_in; y1_ff <= y1_in;
      cx_ff <= cx_in; cy_ff <= cy_in; row_ff <= row_in;
      if (cmd.walk_first) sw_r_ff <= sw_c;
      for (int c = 0; c < 3; c++) begin
         sum_ff[c] <= sum_in[c];
         arem_ff[c] <= arem_in[c];
         anum_ff[c] <= anum_in[c];
         aq_ff[c] <= aq_in[c];
      end
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   // empty box: sums and count are zero, mean output is forced to zero
   assign mean_out.red = (cnt_ff == '0) ? 8'd0 : aq_ff[0];
   assign mean_out.green = (cnt_ff == '0) ? 8'd0 : aq_ff[1];
   assign mean_out.blue = (cnt_ff == '0) ? 8'd0 : aq_ff[2];
endmodule

### sv/bfir_ctrl.sv
// Controller state machine: sequences loads, bounds, box walk and means.
// Depends on bfir_pkg.
module bfir_ctrl #(
   parameter int SUM_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_command,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic csr_ready,
   input  bfir_pkg::stat_type stat,
   output bfir_pkg::cmd_type cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_BOUND = 3'd1;
   localparam logic [2:0] ST_FIX = 3'd2;
   localparam logic [2:0] ST_WALK = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_AVG = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;
   localparam int StepW = $clog2(SUM_BITS + 1) + 1;

   logic [2:0] state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == bfir_pkg::COMMAND_LOAD) begin
               cmd.load = 1'b1;
            end else if (accept) begin
               cmd.start = 1'b1;
               step_in = '0;
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            cmd.bound_step = 1'b1;
            step_in = step_ff + StepW'(1);
            if (step_ff == StepW'(17)) state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.bound_fix = 1'b1;
            state_in = ST_WALK;
            step_in = '0;
         end
         ST_WALK: begin
            // first cycle sets cursors; then one read per cycle
            if (step_ff == '0) begin
               cmd.walk_first = 1'b1;
               step_in = StepW'(1);
               if (stat.box_empty) state_in = ST_DONE;
            end else begin
               cmd.walk_read = 1'b1;
               if (step_ff == StepW'(2)) cmd.walk_acc = 1'b1;
               step_in = StepW'(2);
               if (stat.walk_last) state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.walk_acc = 1'b1;
            state_in = ST_AVG;
            step_in = '0;
         end
         ST_AVG: begin
            if (step_ff == '0) begin
               cmd.avg_start = 1'b1;
            end else begin
               cmd.avg_step = 1'b1;
            end
            step_in = step_ff + StepW'(1);
            if (step_ff == StepW'(SUM_BITS)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end
endmodule
